[rtl/pulse_window_average_unit_assert.svh]
// ----------------------------------------------------------------------------
// Pulse window average unit: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PULSE_WINDOW_AVERAGE_UNIT_ASSERT_SVH
`define PULSE_WINDOW_AVERAGE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwa: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwa: next-cycle check failed");

`endif

[rtl/pwa_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse window average package
// Widths, limits, register indexes, sequencer states and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwa_pkg;

    localparam int PULSE_W    = 16;
    localparam int SCALE_W    = 8;
    localparam int TOTAL_W    = 21;
    localparam int COUNT_W    = 6;
    localparam int AVG_W      = 10;
    localparam int PROD_W     = TOTAL_W + SCALE_W;
    localparam int LIM_W      = 16;
    localparam int QUO_W      = AVG_W;
    localparam int BIT_W      = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RST     = 8'd1;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd12;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [AVG_W-1:0]   AVG_LIMIT = 10'd999;
    // mean > 999 exactly when product >= 1000 * count
    localparam logic [LIM_W-1:0]   SAT_LIMIT = 16'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_SATCHK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             accum;
        logic             mul_load;
        logic             sat_chk;
        logic             div_step;
        logic [BIT_W-1:0] bit_idx;
        logic             out_load;
    } pwa_ctl_t;

    typedef struct packed {
        logic close;
        logic empty;
        logic ge;
    } pwa_sts_t;

endpackage

[rtl/pwa_subunit.sv]
// ----------------------------------------------------------------------------
// Shared compare and subtract unit
// Returns a >= b and a - b; used for the saturation test and every divide step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwa_subunit
    import pwa_pkg::*;
(
    input  logic [PROD_W-1:0] a,
    input  logic [PROD_W-1:0] b,
    output logic              ge,
    output logic [PROD_W-1:0] diff
);

    logic [PROD_W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[PROD_W];
    assign diff = wide[PROD_W-1:0];

endmodule

[rtl/pwa_ctrl.sv]
// ----------------------------------------------------------------------------
// Pulse window average sequencer
// Steps accumulate, multiply, saturation test, divide and output load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwa_ctrl
    import pwa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_stall,
    input  pwa_sts_t sts,
    output logic     in_stall,
    output logic     out_valid,
    output pwa_ctl_t ctl
);

    state_t           state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg & out_stall;
        ctl            = '0;
        ctl.bit_idx    = bit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accum  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.close)
                    state_next = ST_IDLE;
                else if (sts.empty)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.mul_load = 1'b1;
                state_next   = ST_SATCHK;
            end
            ST_SATCHK:
            begin
                ctl.sat_chk = 1'b1;
                if (sts.ge)
                    state_next = ST_DONE;
                else
                begin
                    state_next = ST_DIV;
                    bit_next   = BIT_W'(QUO_W - 1);
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, msb first
                ctl.div_step = 1'b1;
                if (bit_reg == '0)
                    state_next = ST_DONE;
                else
                    bit_next = bit_reg - BIT_W'(1);
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/pwa_datapath.sv]
// ----------------------------------------------------------------------------
// Pulse window average datapath
// Window accumulator, product and remainder registers, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwa_datapath
    import pwa_pkg::*;
#(
    parameter int WINDOW_SLOTS = 32,
    parameter int DROPOUT_SKIP = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pwa_ctl_t           ctl,
    input  logic [PULSE_W-1:0] pulse,
    input  logic [SCALE_W-1:0] scale,
    input  logic [PULSE_W-1:0] min_pulse,
    output pwa_sts_t           sts,
    output logic [AVG_W-1:0]   average,
    output logic               empty_window,
    output logic               saturated
);

    localparam int SLOT_W = $clog2(WINDOW_SLOTS);
    localparam int POS_W  = $clog2(WINDOW_SLOTS + DROPOUT_SKIP + 1);

    localparam logic [POS_W-1:0] SKIP_STEP = POS_W'(DROPOUT_SKIP + 1);
    localparam logic [POS_W-1:0] WIN_END   = POS_W'(WINDOW_SLOTS);

    logic [SLOT_W-1:0]  pos_reg;
    logic               close_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic [LIM_W-1:0]   lim_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic               over_reg;
    logic [AVG_W-1:0]   average_reg;
    logic               empty_reg;
    logic               sat_reg;

    logic [POS_W-1:0]   pos_sum;
    logic               close_now;
    logic               counted;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_upd;
    logic [COUNT_W-1:0] count_upd;
    logic [PROD_W-1:0]  product;
    logic [LIM_W-1:0]   limit;
    logic [PROD_W-1:0]  op_b;
    logic [PROD_W-1:0]  diff;
    logic               ge;
    logic               empty;

    // a dropout moves the position on by the skip plus its own slot
    assign pos_sum   = POS_W'(pos_reg) + ((pulse == '0) ? SKIP_STEP : POS_W'(1));
    assign close_now = (pos_sum >= WIN_END);
    assign counted   = (pulse > min_pulse);
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(pulse);
    assign total_upd = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    assign count_upd = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    assign empty     = (count_reg == '0);

    assign product = total_reg * scale;
    assign limit   = count_reg * SAT_LIMIT;

    assign op_b = ctl.sat_chk ? PROD_W'(lim_reg) : (PROD_W'(count_reg) << ctl.bit_idx);

    pwa_subunit u_sub (
        .a    (rem_reg),
        .b    (op_b),
        .ge   (ge),
        .diff (diff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            close_reg <= 1'b0;
            total_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctl.accum)
            begin
                // excess past the window end is dropped
                pos_reg   <= close_now ? '0 : pos_sum[SLOT_W-1:0];
                close_reg <= close_now;
                if (counted)
                begin
                    total_reg <= total_upd;
                    count_reg <= count_upd;
                end
            end
            if (ctl.out_load)
            begin
                total_reg <= '0;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_load)
        begin
            rem_reg  <= product;
            lim_reg  <= limit;
            quo_reg  <= '0;
            over_reg <= 1'b0;
        end
        if (ctl.sat_chk)
            over_reg <= ge;
        if (ctl.div_step && ge)
        begin
            rem_reg               <= diff;
            quo_reg[ctl.bit_idx]  <= 1'b1;
        end
        if (ctl.out_load)
        begin
            average_reg <= empty ? '0 : (over_reg ? AVG_LIMIT : quo_reg);
            empty_reg   <= empty;
            sat_reg     <= over_reg & ~empty;
        end
    end

    assign sts.close    = close_reg;
    assign sts.empty    = empty;
    assign sts.ge       = ge;
    assign average      = average_reg;
    assign empty_window = empty_reg;
    assign saturated    = sat_reg;

endmodule

[rtl/pulse_window_average_unit.sv]
// ----------------------------------------------------------------------------
// Pulse window average unit
// Windowed, scaled mean of pulse-width readings with saturation at 999.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one pulse reading per beat on in_valid/in_stall. A zero reading is
//   a dropout worth DROPOUT_SKIP + 1 slots; any other reading is one slot.
//   Output: one beat per closed window on out_valid/out_stall carrying
//   average, empty_window and saturated.
//   Config: cfg_valid/cfg_ready write scale (index 0) or min_pulse (index 1)
//   from cfg_data; cfg_ready is always high, other indexes are ignored.
// Sequence:
//   A reading that does not close the window passes the check back to idle.
//   A closing window goes from check to output load if empty; else through
//   multiply and saturation compare to output load if clamped, or through 10
//   divide steps on the shared subtractor first. No reading is taken until idle.
// Reset:
//   Window state clears, scale resets to 1 and min_pulse to 12.
// Back-pressure:
//   A result waits in the output register while out_stall is high and the
//   next reading is still taken; a second result waits until the first
//   has gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_window_average_unit
    import pwa_pkg::*;
#(
    parameter int WINDOW_SLOTS = 32,
    parameter int DROPOUT_SKIP = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PULSE_W-1:0]    pulse,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [AVG_W-1:0]      average,
    output logic                  empty_window,
    output logic                  saturated,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SCALE_W-1:0] scale_reg;
    logic [PULSE_W-1:0] min_pulse_reg;
    pwa_ctl_t           ctl;
    pwa_sts_t           sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_RST;
            min_pulse_reg <= MIN_PULSE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                CFG_MIN_PULSE: min_pulse_reg <= cfg_data[PULSE_W-1:0];
                default:       ;
            endcase
        end
    end

    pwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    pwa_datapath #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .DROPOUT_SKIP (DROPOUT_SKIP)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .pulse        (pulse),
        .scale        (scale_reg),
        .min_pulse    (min_pulse_reg),
        .sts          (sts),
        .average      (average),
        .empty_window (empty_window),
        .saturated    (saturated)
    );

endmodule

[rtl/pwa_checker.sv]
// ----------------------------------------------------------------------------
// Pulse window average port checker
// Port-level properties of the result and input channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pulse_window_average_unit_assert.svh"

module pwa_checker
    import pwa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [AVG_W-1:0] average,
    input logic             empty_window,
    input logic             saturated
);

    // held result beat must not move
    `PWA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(average) && $stable(empty_window) && $stable(saturated))

    `PWA_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && empty_window, average == '0 && !saturated)

    `PWA_ASSERT_NOW(a_sat_clamp, clk, rst_n, out_valid && saturated, average == AVG_LIMIT)

    `PWA_ASSERT_NOW(a_avg_range, clk, rst_n, out_valid, average <= AVG_LIMIT)

    // every accepted reading makes the unit busy, raising in_stall
    `PWA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind pulse_window_average_unit pwa_checker u_pwa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average      (average),
    .empty_window (empty_window),
    .saturated    (saturated)
);
